// ===== sv/locd_pkg.sv =====
`default_nettype none
package locd_pkg;

  localparam int unsigned LockCount = 32;
  localparam int unsigned HoldDepth = 16;
  localparam int unsigned IdW = $clog2(LockCount);
  localparam int unsigned HoldIdxW = (HoldDepth > 1) ? $clog2(HoldDepth) : 1;
  localparam int unsigned HoldCntW = $clog2(HoldDepth + 1);
  localparam int unsigned RankW = $clog2(LockCount + 1);
  localparam int unsigned SpW = $clog2(LockCount + 1);

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StDeadlock  = 3'd1;
  localparam logic [2:0] StRelEmpty  = 3'd2;
  localparam logic [2:0] StRelNotTop = 3'd3;
  localparam logic [2:0] StFull      = 3'd4;
  localparam logic [2:0] StFaulted   = 3'd5;

  typedef struct packed {
    logic       mode;
    logic [4:0] lock_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] cycle_from;
    logic [4:0] cycle_to;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,
    S_INIT,
    S_ROOT,
    S_STEP,
    S_RESULT
  } state_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic take_in;
    logic do_op;
    logic init_walk;
    logic root_step;
    logic walk_step;
    logic load_out;
  } cmd_t;

  // Datapath status back to the controller.
  typedef struct packed {
    logic need_walk;
    logic root_done;
    logic walk_empty;
    logic walk_found;
  } stat_t;

endpackage
`default_nettype wire

// ===== sv/locd_ctrl.sv =====
`default_nettype none
module locd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          out_slot_free,
  input  wire locd_pkg::stat_t st,
  output locd_pkg::cmd_t     cmd,
  output logic               in_stall
);

  locd_pkg::state_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      locd_pkg::S_IDLE: if (in_valid) state_nxt = locd_pkg::S_OP;
      locd_pkg::S_OP: begin
        if (st.need_walk) state_nxt = locd_pkg::S_INIT;
        else state_nxt = locd_pkg::S_RESULT;
      end
      locd_pkg::S_INIT: state_nxt = locd_pkg::S_ROOT;
      locd_pkg::S_ROOT: begin
        if (st.root_done) state_nxt = locd_pkg::S_RESULT;
        else state_nxt = locd_pkg::S_STEP;
      end
      locd_pkg::S_STEP: begin
        if (st.walk_found) state_nxt = locd_pkg::S_RESULT;
        else if (st.walk_empty) state_nxt = locd_pkg::S_ROOT;
      end
      locd_pkg::S_RESULT: if (out_slot_free) state_nxt = locd_pkg::S_IDLE;
      default: state_nxt = locd_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      locd_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.take_in = in_valid;
      end
      locd_pkg::S_OP: cmd.do_op = 1'b1;
      locd_pkg::S_INIT: cmd.init_walk = 1'b1;
      locd_pkg::S_ROOT: cmd.root_step = 1'b1;
      locd_pkg::S_STEP: cmd.walk_step = 1'b1;
      locd_pkg::S_RESULT: cmd.load_out = out_slot_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= locd_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  // One item is processed at a time: input is taken in the idle state alone.
  a_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> state_r == locd_pkg::S_IDLE) else $error("stall low outside idle");
  // An accepted item always goes to the operation step.
  a_take_op: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_in |=> state_r == locd_pkg::S_OP) else $error("no op after transfer");
  // A result is loaded only when the output slot is free.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> out_slot_free) else $error("load into full slot");

endmodule
`default_nettype wire

// ===== sv/locd_dp.sv =====
`default_nettype none
module locd_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire locd_pkg::cmd_t    cmd,
  input  wire locd_pkg::in_item_t in_data,
  input  wire logic              out_stall,
  output locd_pkg::stat_t        st,
  output logic                   out_slot_free,
  output logic                   out_valid,
  output locd_pkg::out_item_t    out_data
);

  localparam int unsigned N = locd_pkg::LockCount;
  localparam int unsigned IW = locd_pkg::IdW;
  localparam int unsigned RW = locd_pkg::RankW;
  localparam int unsigned PW = locd_pkg::SpW;

  logic [N-1:0]  edges_r [N];
  logic [IW-1:0] held_r [locd_pkg::HoldDepth];
  logic [locd_pkg::HoldCntW-1:0] cnt_r;
  logic          fault_r;
  logic          mode_r;
  logic [IW-1:0] id_r;
  logic [2:0]    status_r;
  logic [IW-1:0] from_r, to_r;
  logic          walk_r;

  // Search scratch.
  logic [N-1:0]  seen_r, done_r;
  logic [RW-1:0] rank_r [N];
  logic [RW-1:0] counter_r;
  logic [IW-1:0] wnode_r [N];
  logic [IW:0]   wnext_r [N];
  logic [PW-1:0] sp_r;
  logic [IW:0]   root_r;

  logic          ovalid_r;
  locd_pkg::out_item_t odata_r;

  logic [IW-1:0] top;
  logic          empty, full;
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == locd_pkg::HoldCntW'(locd_pkg::HoldDepth));
  assign top   = held_r[locd_pkg::HoldIdxW'(cnt_r - 1'b1)];

  // Status of the stack operation and whether it records a new edge.
  logic [2:0] op_status;
  logic       op_walk;
  always_comb begin
    op_status = locd_pkg::StOk;
    op_walk   = 1'b0;
    if (fault_r) begin
      op_status = locd_pkg::StFaulted;
    end else if (!mode_r) begin
      if (full) begin
        op_status = locd_pkg::StFull;
      end else if (!empty && top != id_r && !edges_r[top][id_r]) begin
        op_walk = 1'b1;
      end
    end else if (empty) begin
      op_status = locd_pkg::StRelEmpty;
    end else if (top != id_r) begin
      op_status = locd_pkg::StRelNotTop;
    end
  end

  // Walk step: next set bit of the current row at or after the cursor.
  logic [PW-1:0] spm1;
  logic [IW-1:0] here;
  logic [IW:0]   cur;
  logic [N-1:0]  masked;
  logic          hit;
  logic [IW-1:0] j;
  assign spm1 = sp_r - 1'b1;
  assign here = wnode_r[spm1[IW-1:0]];
  assign cur  = wnext_r[spm1[IW-1:0]];

  always_comb begin
    masked = '0;
    for (int k = 0; k < N; k++) begin
      masked[k] = edges_r[here][k] && (k >= int'(cur));
    end
    hit = |masked;
    j = '0;
    for (int k = N - 1; k >= 0; k--) begin
      if (masked[k]) j = IW'(k);
    end
  end

  logic root_seen;
  assign root_seen = seen_r[root_r[IW-1:0]];
  logic back;
  assign back = hit && seen_r[j] && !(rank_r[here] < rank_r[j]) && !done_r[j];

  assign st.need_walk  = walk_r;
  assign st.root_done  = root_r[IW];
  assign st.walk_empty = (sp_r == '0);
  assign st.walk_found = back && (sp_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) edges_r[k] <= '0;
      cnt_r    <= '0;
      fault_r  <= 1'b0;
      ovalid_r <= 1'b0;
      walk_r   <= 1'b0;
    end else begin
      if (cmd.load_out) ovalid_r <= 1'b1;
      else if (!out_stall) ovalid_r <= 1'b0;
      if (cmd.take_in) begin
        mode_r <= in_data.mode;
        id_r   <= in_data.lock_id;
      end
      // Stack operation and edge recording.
      if (cmd.do_op) begin
        status_r <= op_status;
        walk_r   <= op_walk;
        from_r   <= '0;
        to_r     <= '0;
        if (op_walk) edges_r[top][id_r] <= 1'b1;
      end
      // Search setup.
      if (cmd.init_walk) begin
        seen_r    <= '0;
        done_r    <= '0;
        counter_r <= '0;
        root_r    <= '0;
        sp_r      <= '0;
      end
      // Start the next undiscovered root.
      if (cmd.root_step && !root_r[IW]) begin
        if (!root_seen) begin
          seen_r[root_r[IW-1:0]] <= 1'b1;
          rank_r[root_r[IW-1:0]] <= counter_r;
          counter_r <= counter_r + 1'b1;
          wnode_r[0] <= root_r[IW-1:0];
          wnext_r[0] <= '0;
          sp_r <= PW'(1);
        end
        root_r <= root_r + 1'b1;
      end
      // One edge or one node finish of the depth-first walk.
      if (cmd.walk_step && sp_r != '0) begin
        if (!hit) begin
          done_r[here] <= 1'b1;
          sp_r <= spm1;
        end else begin
          wnext_r[spm1[IW-1:0]] <= {1'b0, j} + 1'b1;
          if (!seen_r[j]) begin
            seen_r[j] <= 1'b1;
            rank_r[j] <= counter_r;
            counter_r <= counter_r + 1'b1;
            if (sp_r < PW'(N)) begin
              wnode_r[sp_r[IW-1:0]] <= j;
              wnext_r[sp_r[IW-1:0]] <= '0;
              sp_r <= sp_r + 1'b1;
            end
          end else if (back) begin
            status_r <= locd_pkg::StDeadlock;
            from_r   <= here;
            to_r     <= j;
          end
        end
      end
      // Commit the result and update the stack.
      if (cmd.load_out) begin
        odata_r.status     <= status_r;
        odata_r.cycle_from <= from_r;
        odata_r.cycle_to   <= to_r;
        if (status_r != locd_pkg::StOk && status_r != locd_pkg::StFaulted) begin
          fault_r <= 1'b1;
        end else if (status_r == locd_pkg::StOk) begin
          if (!mode_r) begin
            held_r[locd_pkg::HoldIdxW'(cnt_r)] <= id_r;
            cnt_r <= cnt_r + 1'b1;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
      end
    end
  end

  assign out_slot_free = !ovalid_r || !out_stall;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  // The hold count never exceeds the stack depth.
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= locd_pkg::HoldCntW'(locd_pkg::HoldDepth)) else $error("count overflow");
  // Once latched, the fault stays.
  a_fault: assert property (@(posedge clk) disable iff (!rst_n)
    fault_r |=> fault_r) else $error("fault cleared");
  // A deadlock result always carries a fault afterwards.
  a_dl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out && status_r == locd_pkg::StDeadlock |=> fault_r) else $error("no fault");

endmodule
`default_nettype wire

// ===== sv/lock_order_cycle_detector_unit.sv =====
`default_nettype none
// Lock-order cycle detector.
// Input channel in_valid/in_stall/in_data carries one acquire or release of a
// lock id; each transfer produces exactly one result on out_valid/out_stall/
// out_data with a status and, for a deadlock, the back edge found.
// One item is processed at a time; no new item is taken until the last
// one's result is loaded. A plain stack operation passes the take,
// operation and result states. An acquire that adds a new edge to the order
// graph runs a depth-first search from each lock id not yet reached as root,
// one edge or node finish per walk step, until a back edge is found or all
// roots are done. The result sits in an output register; while out_stall
// holds, the block keeps it and can take the next item but holds back its
// result. After a deadlock or stack error the block latches a fault and
// answers every later item with the faulted status.
// Synchronous reset clears the order graph, the held count and the fault.
module lock_order_cycle_detector_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire locd_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output locd_pkg::out_item_t     out_data
);

  locd_pkg::cmd_t  cmd;
  locd_pkg::stat_t st;
  logic            slot_free;

  locd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .out_slot_free(slot_free),
    .st(st), .cmd(cmd), .in_stall(in_stall)
  );

  locd_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_data(in_data), .out_stall(out_stall),
    .st(st), .out_slot_free(slot_free), .out_valid(out_valid), .out_data(out_data)
  );

endmodule
`default_nettype wire
